// File: rtl/core/nvg_pkg.sv
// ----------------------------------------------------------------------------
// nvg_pkg
// Request and voice-state codes, stream field layout and config register
// indexes for the note voice gate.
// ----------------------------------------------------------------------------
package nvg_pkg;

	typedef enum logic [1:0] {
		REQ_PLAY   = 2'd0,
		REQ_TIME   = 2'd1,
		REQ_SAMPLE = 2'd2,
		REQ_RESET  = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		MODE_IDLE   = 3'b001,
		MODE_PLAY   = 3'b010,
		MODE_RETRIG = 3'b100
	} mode_t;

	localparam logic [1:0] VS_IDLE   = 2'd0;
	localparam logic [1:0] VS_PLAY   = 2'd1;
	localparam logic [1:0] VS_RETRIG = 2'd2;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_RETRIG  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL = 1'd1;

	localparam int PITCH_W   = 16;
	localparam int FTIME_W   = 32;
	localparam int SAMPLES_W = 16;
	localparam int CHAN_W    = 4;

	// Input tdata layout
	localparam int OFS_PITCH   = 0;
	localparam int OFS_START   = OFS_PITCH + PITCH_W;
	localparam int OFS_END     = OFS_START + FTIME_W;
	localparam int OFS_NOW     = OFS_END + FTIME_W;
	localparam int OFS_SAMPLES = OFS_NOW + FTIME_W;
	localparam int OFS_CLEAR   = OFS_SAMPLES + SAMPLES_W;
	localparam int IN_DATA_W   = 136;

	// Output tdata layout
	localparam int OFS_GATE    = 0;
	localparam int OFS_CV      = 1;
	localparam int OFS_VSTATE  = OFS_CV + PITCH_W;
	localparam int OFS_ENDED   = OFS_VSTATE + 2;
	localparam int OFS_SOUND   = OFS_ENDED + 1;
	localparam int OFS_CHAN    = OFS_SOUND + PITCH_W;
	localparam int OUT_DATA_W  = OFS_CHAN + CHAN_W;

endpackage

// File: rtl/core/note_voice_gate_with_retrigger.sv
// ----------------------------------------------------------------------------
// note_voice_gate_with_retrigger
// One sequencer voice: gate and pitch CV with back-to-back note retrigger.
// ----------------------------------------------------------------------------
// Each request transaction yields exactly one result transaction. A request is
// captured in an input register; when the output register is free or drained,
// the voice state is updated and the result is loaded into the output register
// at the same edge, and one request is taken every clock while the result stream does not stall. The
// sustained rate is set by the voice state update; the output register only
// holds the input side when a result waits and the input register is full.
module note_voice_gate_with_retrigger #(
	parameter int TIME_BITS = 32,
	parameter int CV_BITS   = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// config write port
	input  logic                                  cfg_we,
	input  logic [nvg_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [nvg_pkg::CFG_DATA_W-1:0]        cfg_data,
	// request stream
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// note_pitch, note_start, note_end, metric_now, sample_count, clear_gate
	input  logic [nvg_pkg::IN_DATA_W-1:0]         s_axis_tdata,
	// req_type
	input  logic [1:0]                            s_axis_tuser,
	// result stream
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// gate_out, cv_out, voice_state, note_ended, sounding_pitch, out_channel
	output logic [nvg_pkg::OUT_DATA_W-1:0]        m_axis_tdata
);

	localparam int PW = ((CV_BITS > nvg_pkg::PITCH_W) ? CV_BITS : nvg_pkg::PITCH_W) + 1;
	localparam logic signed [PW-1:0] CV_MAX_W = PW'((1 <<< (CV_BITS - 1)) - 1);
	localparam logic signed [PW-1:0] CV_MIN_W = PW'(-(1 <<< (CV_BITS - 1)));
	localparam int TW = TIME_BITS + nvg_pkg::FTIME_W;

	// config registers
	logic [nvg_pkg::CFG_DATA_W-1:0] retrig_q;
	logic [nvg_pkg::CHAN_W-1:0]     channel_q;

	// input register
	logic                                s1_valid_q;
	nvg_pkg::req_t                       req_s1;
	logic signed [nvg_pkg::PITCH_W-1:0]  pitch_s1;
	logic [nvg_pkg::FTIME_W-1:0]         start_s1;
	logic [nvg_pkg::FTIME_W-1:0]         end_s1;
	logic [nvg_pkg::FTIME_W-1:0]         now_s1;
	logic [nvg_pkg::SAMPLES_W-1:0]       samples_s1;
	logic                                clear_s1;

	// voice state
	nvg_pkg::mode_t               mode_q, mode_d;
	logic [TIME_BITS-1:0]         off_time_q, off_time_d;
	logic                         off_valid_q, off_valid_d;
	logic [TIME_BITS-1:0]         last_off_q, last_off_d;
	logic                         last_valid_q, last_valid_d;
	logic signed [CV_BITS-1:0]    played_q, played_d;
	logic signed [CV_BITS-1:0]    held_pitch_q, held_pitch_d;
	logic [TIME_BITS-1:0]         held_end_q, held_end_d;
	logic [nvg_pkg::SAMPLES_W-1:0] countdown_q, countdown_d;
	logic                         gate_q, gate_d;
	logic signed [CV_BITS-1:0]    cv_q, cv_d;

	// result register
	logic                          out_valid_q;
	logic [nvg_pkg::OUT_DATA_W-1:0] out_data_q;

	logic                          advance;
	logic                          ended;
	logic [TW-1:0]                 start_ext, end_ext, now_ext;
	logic [TIME_BITS-1:0]          start_t, end_t, now_t;
	logic signed [PW-1:0]          pitch_ext, pitch_sat;
	logic signed [CV_BITS-1:0]     pitch_cv;
	logic signed [PW-1:0]          cv_ext, played_ext;
	logic [1:0]                    vstate;
	logic [nvg_pkg::OUT_DATA_W-1:0] out_data_d;

	assign advance       = s1_valid_q && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !s1_valid_q || advance;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retrig_q  <= nvg_pkg::CFG_DATA_W'(1);
			channel_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				nvg_pkg::CFG_RETRIG:  retrig_q  <= cfg_data;
				nvg_pkg::CFG_CHANNEL: channel_q <= cfg_data[nvg_pkg::CHAN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_axis_tready) begin
			s1_valid_q <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			req_s1     <= nvg_pkg::req_t'(s_axis_tuser);
			pitch_s1   <= s_axis_tdata[nvg_pkg::OFS_PITCH +: nvg_pkg::PITCH_W];
			start_s1   <= s_axis_tdata[nvg_pkg::OFS_START +: nvg_pkg::FTIME_W];
			end_s1     <= s_axis_tdata[nvg_pkg::OFS_END +: nvg_pkg::FTIME_W];
			now_s1     <= s_axis_tdata[nvg_pkg::OFS_NOW +: nvg_pkg::FTIME_W];
			samples_s1 <= s_axis_tdata[nvg_pkg::OFS_SAMPLES +: nvg_pkg::SAMPLES_W];
			clear_s1   <= s_axis_tdata[nvg_pkg::OFS_CLEAR];
		end
	end

	// fit request fields to the internal widths
	always_comb begin
		start_ext = {{TIME_BITS{1'b0}}, start_s1};
		end_ext   = {{TIME_BITS{1'b0}}, end_s1};
		now_ext   = {{TIME_BITS{1'b0}}, now_s1};
		start_t   = start_ext[TIME_BITS-1:0];
		end_t     = end_ext[TIME_BITS-1:0];
		now_t     = now_ext[TIME_BITS-1:0];
		pitch_ext = PW'(pitch_s1);
		if (pitch_ext > CV_MAX_W) begin
			pitch_sat = CV_MAX_W;
		end else if (pitch_ext < CV_MIN_W) begin
			pitch_sat = CV_MIN_W;
		end else begin
			pitch_sat = pitch_ext;
		end
		pitch_cv = pitch_sat[CV_BITS-1:0];
	end

	always_comb begin
		mode_d       = mode_q;
		off_time_d   = off_time_q;
		off_valid_d  = off_valid_q;
		last_off_d   = last_off_q;
		last_valid_d = last_valid_q;
		played_d     = played_q;
		held_pitch_d = held_pitch_q;
		held_end_d   = held_end_q;
		countdown_d  = countdown_q;
		gate_d       = gate_q;
		cv_d         = cv_q;
		ended        = 1'b0;
		unique case (req_s1)
			nvg_pkg::REQ_PLAY: begin
				if (last_valid_q && start_t == last_off_q) begin
					mode_d       = nvg_pkg::MODE_RETRIG;
					gate_d       = 1'b0;
					held_pitch_d = pitch_cv;
					held_end_d   = end_t;
					countdown_d  = (retrig_q == '0) ? nvg_pkg::SAMPLES_W'(1) : retrig_q;
				end else begin
					played_d    = pitch_cv;
					off_time_d  = end_t;
					off_valid_d = 1'b1;
					mode_d      = nvg_pkg::MODE_PLAY;
					cv_d        = pitch_cv;
					gate_d      = 1'b1;
				end
			end
			nvg_pkg::REQ_TIME: begin
				if (off_valid_q && off_time_q <= now_t) begin
					gate_d       = 1'b0;
					last_off_d   = off_time_q;
					last_valid_d = 1'b1;
					off_valid_d  = 1'b0;
					mode_d       = nvg_pkg::MODE_IDLE;
					ended        = 1'b1;
				end
			end
			nvg_pkg::REQ_SAMPLE: begin
				if (countdown_q != '0) begin
					if (samples_s1 >= countdown_q) begin
						countdown_d = '0;
						mode_d      = nvg_pkg::MODE_PLAY;
						cv_d        = held_pitch_q;
						played_d    = held_pitch_q;
						off_time_d  = held_end_q;
						off_valid_d = 1'b1;
						gate_d      = 1'b1;
					end else begin
						countdown_d = countdown_q - samples_s1;
					end
				end
			end
			nvg_pkg::REQ_RESET: begin
				off_valid_d  = 1'b0;
				played_d     = CV_MIN_W[CV_BITS-1:0];
				last_valid_d = 1'b0;
				mode_d       = nvg_pkg::MODE_IDLE;
				countdown_d  = '0;
				if (clear_s1) begin
					gate_d = 1'b0;
				end
			end
		endcase
	end

	always_comb begin
		unique case (mode_d)
			nvg_pkg::MODE_IDLE:   vstate = nvg_pkg::VS_IDLE;
			nvg_pkg::MODE_PLAY:   vstate = nvg_pkg::VS_PLAY;
			nvg_pkg::MODE_RETRIG: vstate = nvg_pkg::VS_RETRIG;
			default:              vstate = nvg_pkg::VS_IDLE;
		endcase
		cv_ext     = PW'(cv_d);
		played_ext = PW'(played_d);
		out_data_d = {channel_q, played_ext[nvg_pkg::PITCH_W-1:0], ended, vstate,
			cv_ext[nvg_pkg::PITCH_W-1:0], gate_d};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= nvg_pkg::MODE_IDLE;
			off_time_q   <= '0;
			off_valid_q  <= 1'b0;
			last_off_q   <= '0;
			last_valid_q <= 1'b0;
			played_q     <= CV_MIN_W[CV_BITS-1:0];
			held_pitch_q <= '0;
			held_end_q   <= '0;
			countdown_q  <= '0;
			gate_q       <= 1'b0;
			cv_q         <= '0;
		end else if (advance) begin
			mode_q       <= mode_d;
			off_time_q   <= off_time_d;
			off_valid_q  <= off_valid_d;
			last_off_q   <= last_off_d;
			last_valid_q <= last_valid_d;
			played_q     <= played_d;
			held_pitch_q <= held_pitch_d;
			held_end_q   <= held_end_d;
			countdown_q  <= countdown_d;
			gate_q       <= gate_d;
			cv_q         <= cv_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= out_data_d;
		end
	end

	a_advance_loads: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("processed request produced no result");

	a_retrig_counts: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == nvg_pkg::MODE_RETRIG |-> countdown_q != '0)
		else $error("retriggering with an empty countdown");

	a_reset_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && req_s1 == nvg_pkg::REQ_RESET |=> countdown_q == '0 && !off_valid_q
			&& !last_valid_q)
		else $error("reset request left timing state");

	a_ended_gate_low: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_data_q[nvg_pkg::OFS_ENDED] |-> !out_data_q[nvg_pkg::OFS_GATE]
			&& out_data_q[nvg_pkg::OFS_VSTATE +: 2] == nvg_pkg::VS_IDLE)
		else $error("ended note with gate high or voice not idle");

endmodule
